// ===== rtl/core/tcpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpsm_pkg
// Shared types, widths and constants of the target centering pid stick mixer.
// ----------------------------------------------------------------------------
package tcpsm_pkg;

    // defaults of the top level parameters
    localparam int GAIN_FRACTION_BITS_DEF = 10;
    localparam int INTEGRAL_BITS_DEF      = 24;

    // fixed field widths
    localparam int POS_W      = 10;
    localparam int DIM_W      = 11;
    localparam int GAIN_W     = 16;
    localparam int ERR_W      = 12;
    localparam int LAST_W     = 11;
    localparam int CMD_W      = 11;
    localparam int VCORR_W    = 32;
    localparam int REG_IDX_W  = 3;
    localparam int REG_DATA_W = 16;

    // stick pulse widths in microseconds
    localparam logic [CMD_W-1:0] RUDDER_MID     = 11'd1504;
    localparam logic [CMD_W-1:0] THROTTLE_TRACK = 11'd1580;
    localparam logic [CMD_W-1:0] THROTTLE_IDLE  = 11'd1504;
    localparam logic [CMD_W-1:0] AILERON_MID    = 11'd1516;
    localparam logic [CMD_W-1:0] ELEVATOR_MID   = 11'd1476;
    localparam logic [CMD_W-1:0] RUD_MAX        = 11'd1900;
    localparam logic [CMD_W-1:0] RUD_MIN        = 11'd1110;

    // deadband is frame_width / 20, done as a multiply by 3277 / 2^16
    localparam int                RECIP_W        = 12;
    localparam logic [RECIP_W-1:0] DEADBAND_RECIP = 12'd3277;
    localparam int                DEADBAND_SHIFT = 16;

    // register map
    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAME_WIDTH     = 3'd0,
        REG_FRAME_HEIGHT    = 3'd1,
        REG_YAW_PROP_GAIN   = 3'd2,
        REG_YAW_INTEG_GAIN  = 3'd3,
        REG_YAW_DERIV_GAIN  = 3'd4,
        REG_LIFT_PROP_GAIN  = 3'd5,
        REG_LIFT_INTEG_GAIN = 3'd6,
        REG_LIFT_DERIV_GAIN = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
        logic [GAIN_W-1:0] yaw_prop_gain;
        logic [GAIN_W-1:0] yaw_integ_gain;
        logic [GAIN_W-1:0] yaw_deriv_gain;
        logic [GAIN_W-1:0] lift_prop_gain;
        logic [GAIN_W-1:0] lift_integ_gain;
        logic [GAIN_W-1:0] lift_deriv_gain;
    } cfg_t;

    typedef struct packed {
        logic             target_found;
        logic [POS_W-1:0] x_position;
        logic [POS_W-1:0] y_position;
    } track_item_t;

    typedef struct packed {
        logic        [CMD_W-1:0]   throttle_command;
        logic        [CMD_W-1:0]   rudder_command;
        logic        [CMD_W-1:0]   elevator_command;
        logic        [CMD_W-1:0]   aileron_command;
        logic signed [ERR_W-1:0]   horizontal_error;
        logic signed [ERR_W-1:0]   vertical_error;
        logic signed [VCORR_W-1:0] vertical_correction;
    } stick_item_t;

    // error stage to mix stage
    typedef struct packed {
        logic                    found;
        logic signed [ERR_W-1:0] horiz_err;
        logic signed [ERR_W-1:0] vert_err;
        logic signed [ERR_W-1:0] horiz_diff;
        logic signed [ERR_W-1:0] vert_diff;
    } err_item_t;

endpackage

// ===== rtl/core/tcpsm_chan_if.sv =====
// ----------------------------------------------------------------------------
// tcpsm_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface tcpsm_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/tcpsm_err_stage.sv =====
// ----------------------------------------------------------------------------
// tcpsm_err_stage
// Error, difference and saturating integral per axis; holds the pid state.
// ----------------------------------------------------------------------------
module tcpsm_err_stage
    import tcpsm_pkg::*;
#(
    parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cfg_t                            cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  track_item_t                     in_item,
    input  logic                            advance,
    output logic                            s1_valid,
    output err_item_t                       s1_item,
    output logic signed [INTEGRAL_BITS-1:0] integ_horiz,
    output logic signed [INTEGRAL_BITS-1:0] integ_vert
);

    localparam int IB = INTEGRAL_BITS;

    function automatic logic signed [IB-1:0] sat_integ(input logic signed [IB:0] v);
        if (v[IB] != v[IB-1])
        begin
            sat_integ = v[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}};
        end
        else
        begin
            sat_integ = v[IB-1:0];
        end
    endfunction

    logic                     valid_reg, valid_next;
    err_item_t                item_reg, item_next;
    logic signed [LAST_W-1:0] last_h_reg, last_h_next;
    logic signed [LAST_W-1:0] last_v_reg, last_v_next;
    logic signed [IB-1:0]     integ_h_reg, integ_h_next;
    logic signed [IB-1:0]     integ_v_reg, integ_v_next;

    logic                    accept;
    logic signed [ERR_W-1:0] eh, ev, dh, dv;
    logic signed [IB:0]      sum_h, sum_v;

    assign in_ready = !valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign eh = $signed({2'b00, in_item.x_position})
              - $signed({2'b00, cfg.frame_width[DIM_W-1:1]});
    assign ev = $signed({2'b00, cfg.frame_height[DIM_W-1:1]})
              - $signed({2'b00, in_item.y_position});
    assign dh = eh - ERR_W'(last_h_reg);
    assign dv = ev - ERR_W'(last_v_reg);

    assign sum_h = (IB+1)'(integ_h_reg) + (IB+1)'(eh);
    assign sum_v = (IB+1)'(integ_v_reg) + (IB+1)'(ev);

    always_comb
    begin
        valid_next   = valid_reg;
        item_next    = item_reg;
        last_h_next  = last_h_reg;
        last_v_next  = last_v_reg;
        integ_h_next = integ_h_reg;
        integ_v_next = integ_v_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            if (in_item.target_found)
            begin
                item_next.found      = 1'b1;
                item_next.horiz_err  = eh;
                item_next.vert_err   = ev;
                item_next.horiz_diff = dh;
                item_next.vert_diff  = dv;
                last_h_next          = eh[LAST_W-1:0];
                last_v_next          = ev[LAST_W-1:0];
                integ_h_next         = sat_integ(sum_h);
                integ_v_next         = sat_integ(sum_v);
            end
            else
            begin
                item_next = '0;
            end
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            last_h_reg  <= '0;
            last_v_reg  <= '0;
            integ_h_reg <= '0;
            integ_v_reg <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            last_h_reg  <= last_h_next;
            last_v_reg  <= last_v_next;
            integ_h_reg <= integ_h_next;
            integ_v_reg <= integ_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign s1_valid    = valid_reg;
    assign s1_item     = item_reg;
    assign integ_horiz = integ_h_reg;
    assign integ_vert  = integ_v_reg;

endmodule

// ===== rtl/core/tcpsm_mix_stage.sv =====
// ----------------------------------------------------------------------------
// tcpsm_mix_stage
// Pid sums, rudder deadband and hold, stick mixing, result register.
// ----------------------------------------------------------------------------
module tcpsm_mix_stage
    import tcpsm_pkg::*;
#(
    parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF,
    parameter int INTEGRAL_BITS      = INTEGRAL_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cfg_t                            cfg,
    input  logic                            s1_valid,
    input  err_item_t                       s1_item,
    input  logic signed [INTEGRAL_BITS-1:0] integ_horiz,
    input  logic signed [INTEGRAL_BITS-1:0] integ_vert,
    output logic                            advance,
    output logic                            out_valid,
    input  logic                            out_ready,
    output stick_item_t                     out_item
);

    localparam int IB    = INTEGRAL_BITS;
    localparam int GFB   = GAIN_FRACTION_BITS;
    localparam int PE_W  = ERR_W + GAIN_W + 1;
    localparam int PI_W  = IB + GAIN_W + 1;
    localparam int SUM_W = IB + 20;
    localparam int BAND_W = DIM_W + RECIP_W - DEADBAND_SHIFT;
    localparam int PROD_W = DIM_W + RECIP_W;

    localparam logic signed [SUM_W-1:0] ONE_M1   = SUM_W'((64'sd1 <<< GFB) - 64'sd1);
    localparam logic signed [SUM_W-1:0] RUD_BIAS = SUM_W'(RUDDER_MID) << GFB;
    localparam logic signed [SUM_W-1:0] RUD_HI   = SUM_W'(RUD_MAX);
    localparam logic signed [SUM_W-1:0] RUD_LO   = SUM_W'(RUD_MIN);
    localparam logic signed [SUM_W-1:0] V_HI     = SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] V_LO     = -V_HI - SUM_W'(1);

    // division by 2^GFB rounding toward zero
    function automatic logic signed [SUM_W-1:0] trunc_div(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] bias;
        bias      = v[SUM_W-1] ? ONE_M1 : '0;
        trunc_div = (v + bias) >>> GFB;
    endfunction

    logic              valid_reg, valid_next;
    stick_item_t       item_reg, item_next;
    logic [CMD_W-1:0]  held_reg, held_next;

    logic                    move;
    logic signed [PE_W-1:0]  ph_e, ph_d, pv_e, pv_d;
    logic signed [PI_W-1:0]  ph_i, pv_i;
    logic signed [SUM_W-1:0] sum_h, sum_v, q_rud, q_v;
    logic [CMD_W-1:0]        rud_calc, held_shown;
    logic [VCORR_W-1:0]      vcorr;
    logic [PROD_W-1:0]       band_prod;
    logic [BAND_W-1:0]       band;
    logic [ERR_W-1:0]        abs_h;
    logic                    outside;

    assign advance = !valid_reg || out_ready;
    assign move    = advance && s1_valid;

    // products, all in parallel
    assign ph_e = s1_item.horiz_err  * $signed({1'b0, cfg.yaw_prop_gain});
    assign ph_d = s1_item.horiz_diff * $signed({1'b0, cfg.yaw_deriv_gain});
    assign ph_i = integ_horiz        * $signed({1'b0, cfg.yaw_integ_gain});
    assign pv_e = s1_item.vert_err   * $signed({1'b0, cfg.lift_prop_gain});
    assign pv_d = s1_item.vert_diff  * $signed({1'b0, cfg.lift_deriv_gain});
    assign pv_i = integ_vert         * $signed({1'b0, cfg.lift_integ_gain});

    assign sum_h = SUM_W'(ph_e) + SUM_W'(ph_d) + SUM_W'(ph_i);
    assign sum_v = SUM_W'(pv_e) + SUM_W'(pv_d) + SUM_W'(pv_i);

    assign q_rud = trunc_div(sum_h + RUD_BIAS);
    assign q_v   = trunc_div(sum_v);

    always_comb
    begin
        if (q_rud > RUD_HI)
        begin
            rud_calc = RUD_MAX;
        end
        else if (q_rud < RUD_LO)
        begin
            rud_calc = RUD_MIN;
        end
        else
        begin
            rud_calc = q_rud[CMD_W-1:0];
        end

        if (q_v > V_HI)
        begin
            vcorr = V_HI[VCORR_W-1:0];
        end
        else if (q_v < V_LO)
        begin
            vcorr = V_LO[VCORR_W-1:0];
        end
        else
        begin
            vcorr = q_v[VCORR_W-1:0];
        end
    end

    // deadband of frame_width / 20
    assign band_prod = PROD_W'(cfg.frame_width) * PROD_W'(DEADBAND_RECIP);
    assign band      = band_prod[PROD_W-1:DEADBAND_SHIFT];
    assign abs_h     = s1_item.horiz_err[ERR_W-1] ? ERR_W'(-s1_item.horiz_err)
                                                  : ERR_W'(s1_item.horiz_err);
    assign outside   = abs_h > ERR_W'(band);

    // held value is zero only after reset
    assign held_shown = (held_reg < RUD_MIN) ? RUD_MIN : held_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        held_next  = held_reg;
        if (move)
        begin
            valid_next                 = 1'b1;
            item_next.elevator_command = ELEVATOR_MID;
            item_next.aileron_command  = AILERON_MID;
            if (s1_item.found)
            begin
                item_next.throttle_command    = THROTTLE_TRACK;
                item_next.horizontal_error    = s1_item.horiz_err;
                item_next.vertical_error      = s1_item.vert_err;
                item_next.vertical_correction = vcorr;
                if (outside)
                begin
                    held_next                = rud_calc;
                    item_next.rudder_command = rud_calc;
                end
                else
                begin
                    item_next.rudder_command = held_shown;
                end
            end
            else
            begin
                held_next                     = RUDDER_MID;
                item_next.throttle_command    = THROTTLE_IDLE;
                item_next.rudder_command      = RUDDER_MID;
                item_next.horizontal_error    = '0;
                item_next.vertical_error      = '0;
                item_next.vertical_correction = '0;
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            held_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/core/target_centering_pid_stick_mixer.sv =====
// ----------------------------------------------------------------------------
// target_centering_pid_stick_mixer
// Per-frame pid on the tracked target position, mixed into four stick pulses.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake        payload
//  -------  ---  ---------------  ------------------------------------------
//  track    in   valid / ready    target_found, x_position, y_position
//  stick    out  valid / ready    four commands, both errors, vertical corr
//  cfg_*    in   cfg_we only      cfg_index selects one of eight registers
//
//  stage one register, then result register; one item per cycle unless stalled
//  stage one: error, difference and saturating integral; pid state updates here
//  stage two: six parallel gain multiplies, sums, rudder hold, result register
//  a stalled result holds the result register; stage one still takes one item
//  reset clears valids, pid state and held rudder and loads register defaults
//
module target_centering_pid_stick_mixer
    import tcpsm_pkg::*;
#(
    parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF,
    parameter int INTEGRAL_BITS      = INTEGRAL_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [REG_DATA_W-1:0] cfg_data,
    tcpsm_chan_if.sink            track,
    tcpsm_chan_if.source          stick
);

    // configuration registers
    cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_FRAME_WIDTH:     cfg_next.frame_width     = cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT:    cfg_next.frame_height    = cfg_data[DIM_W-1:0];
                REG_YAW_PROP_GAIN:   cfg_next.yaw_prop_gain   = cfg_data;
                REG_YAW_INTEG_GAIN:  cfg_next.yaw_integ_gain  = cfg_data;
                REG_YAW_DERIV_GAIN:  cfg_next.yaw_deriv_gain  = cfg_data;
                REG_LIFT_PROP_GAIN:  cfg_next.lift_prop_gain  = cfg_data;
                REG_LIFT_INTEG_GAIN: cfg_next.lift_integ_gain = cfg_data;
                REG_LIFT_DERIV_GAIN: cfg_next.lift_deriv_gain = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width     <= 11'd100;
            cfg_reg.frame_height    <= 11'd100;
            cfg_reg.yaw_prop_gain   <= 16'd4403;   // about 4.3 in q.10
            cfg_reg.yaw_integ_gain  <= 16'd10;     // about 0.01
            cfg_reg.yaw_deriv_gain  <= 16'd0;
            cfg_reg.lift_prop_gain  <= 16'd2048;
            cfg_reg.lift_integ_gain <= 16'd10;
            cfg_reg.lift_deriv_gain <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // stage one to stage two
    logic                            advance;
    logic                            s1_valid;
    err_item_t                       s1_item;
    logic signed [INTEGRAL_BITS-1:0] integ_horiz;
    logic signed [INTEGRAL_BITS-1:0] integ_vert;

    tcpsm_err_stage #(
        .INTEGRAL_BITS (INTEGRAL_BITS)
    ) u_err (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (track.valid),
        .in_ready    (track.ready),
        .in_item     (track.payload),
        .advance     (advance),
        .s1_valid    (s1_valid),
        .s1_item     (s1_item),
        .integ_horiz (integ_horiz),
        .integ_vert  (integ_vert)
    );

    // result register and rudder hold live in the mix stage
    tcpsm_mix_stage #(
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS),
        .INTEGRAL_BITS      (INTEGRAL_BITS)
    ) u_mix (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .s1_valid    (s1_valid),
        .s1_item     (s1_item),
        .integ_horiz (integ_horiz),
        .integ_vert  (integ_vert),
        .advance     (advance),
        .out_valid   (stick.valid),
        .out_ready   (stick.ready),
        .out_item    (stick.payload)
    );

endmodule
